// ----- hw/rtl/fima_pkg.sv -----
package fima_pkg;

    localparam int N_CELLS = 64;
    localparam int KEY_W   = 32;

    localparam logic [1:0] OP_CLAIM = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;
    localparam logic [1:0] OP_UNDEF = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DROP,
        ACT_SET_LO,
        ACT_SET_HI,
        ACT_SPLIT,
        ACT_JOIN,
        ACT_INSERT,
        ACT_PREV_HI
    } act_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
    } entry_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic fa;
        logic fb;
        logic fc;
    } flags_t;

    typedef struct packed {
        logic             apply;
        act_t             act;
        logic [KEY_W-1:0] va;
        logic [KEY_W-1:0] vb;
    } ctl_t;

    typedef struct packed {
        logic sel;
        logic sel_prev;
        logic sel_next;
        logic above;
        logic ge;
    } pos_t;

endpackage

// ----- hw/rtl/free_interval_map_allocator_unit.sv -----
// Steps: an accepted command is registered, each interval cell compares it, a
// first-hit select picks one cell, then every cell shifts or updates at once
// and the result strobe is raised with that update. A new command is accepted
// only while busy is low, after the previous one has been applied.
// Reset: the table holds one interval covering every key; busy and done clear.
// The receiver cannot stall: done is high for exactly one cycle per command.
module free_interval_map_allocator_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic [fima_pkg::KEY_W-1:0]   key,
    input  logic [fima_pkg::KEY_W-1:0]   run_length,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [fima_pkg::KEY_W-1:0]   found_key
);

    localparam int N = fima_pkg::N_CELLS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_FIND,
        S_APPLY
    } state_t;

    state_t state_reg;
    fima_pkg::cmd_t cmd_reg;
    fima_pkg::ctl_t ctl_reg;
    fima_pkg::ctl_t ctl_cells;
    logic [N:0] sel_reg;
    logic [N:0] ge_reg;
    logic done_reg;
    logic [1:0] status_reg;
    logic [fima_pkg::KEY_W-1:0] found_reg;

    fima_pkg::entry_t ent [N];
    fima_pkg::flags_t flg [N];

    logic [N-1:0] valid_v;
    logic [N-1:0] hit_v;
    logic [N-1:0] fa_v;
    logic [N-1:0] fb_v;
    logic [N-1:0] fc_v;
    logic [N:0] hit_x;
    logic [N:0] sel_x;
    logic [N:0] ge_x;
    logic [fima_pkg::KEY_W-1:0] lo_sel;
    logic any_hit;
    logic fa_s;
    logic fb_s;
    logic fc_s;
    logic pa_s;
    logic pb_s;
    logic room;
    fima_pkg::act_t act_f;
    logic [fima_pkg::KEY_W-1:0] va_f;
    logic [fima_pkg::KEY_W-1:0] vb_f;
    logic [1:0] st_f;
    logic [fima_pkg::KEY_W-1:0] found_f;

    assign ctl_cells.apply = (state_reg == S_APPLY);
    assign ctl_cells.act   = (state_reg == S_APPLY) ? ctl_reg.act : fima_pkg::ACT_NONE;
    assign ctl_cells.va    = ctl_reg.va;
    assign ctl_cells.vb    = ctl_reg.vb;

    genvar j;
    generate
        for (j = 0; j < N; j++)
        begin : g_cell
            fima_pkg::entry_t left_e;
            fima_pkg::entry_t right_e;
            fima_pkg::pos_t   pos;

            if (j == 0)
            begin : g_first
                assign left_e       = '0;
                assign pos.sel_prev = 1'b0;
            end
            else
            begin : g_mid
                assign left_e       = ent[j-1];
                assign pos.sel_prev = sel_reg[j-1];
            end

            if (j == N - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = ent[j+1];
            end

            assign pos.sel      = sel_reg[j];
            assign pos.sel_next = sel_reg[j+1];
            assign pos.ge       = ge_reg[j];
            assign pos.above    = ge_reg[j] & ~sel_reg[j];

            fima_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .head  (j == 0),
                .eval  (state_reg == S_EVAL),
                .cmd   (cmd_reg),
                .ctl   (ctl_cells),
                .pos   (pos),
                .left  (left_e),
                .right (right_e),
                .ent   (ent[j]),
                .flags (flg[j])
            );

            assign valid_v[j] = ent[j].valid;
            assign hit_v[j]   = flg[j].hit;
            assign fa_v[j]    = flg[j].fa;
            assign fb_v[j]    = flg[j].fb;
            assign fc_v[j]    = flg[j].fc;
        end
    endgenerate

    assign hit_x = {cmd_reg.op == fima_pkg::OP_FREE, hit_v};
    assign sel_x = hit_x & (~hit_x + 1'b1);
    assign ge_x  = ~(sel_x - 1'b1);

    always_comb
    begin
        lo_sel = '0;
        for (int i = 0; i < N; i++)
        begin
            lo_sel = lo_sel | ({fima_pkg::KEY_W{sel_x[i]}} & ent[i].lo);
        end
    end

    assign any_hit = |sel_x;
    assign fa_s    = |(sel_x[N-1:0] & fa_v);
    assign fb_s    = |(sel_x[N-1:0] & fb_v);
    assign fc_s    = |(sel_x[N-1:0] & fc_v);
    assign pa_s    = |(sel_x[N:1] & fa_v);
    assign pb_s    = |(sel_x[N:1] & fb_v);
    assign room    = ~valid_v[N-1];

    always_comb
    begin
        act_f   = fima_pkg::ACT_NONE;
        va_f    = '0;
        vb_f    = '0;
        st_f    = fima_pkg::ST_MISS;
        found_f = cmd_reg.key;
        case (cmd_reg.op)
            fima_pkg::OP_CLAIM:
            begin
                if (any_hit)
                begin
                    st_f = fima_pkg::ST_DONE;
                    if (fa_s && fb_s)
                    begin
                        act_f = fima_pkg::ACT_DROP;
                    end
                    else if (fa_s)
                    begin
                        act_f = fima_pkg::ACT_SET_LO;
                        va_f  = cmd_reg.key + 1'b1;
                    end
                    else if (fb_s)
                    begin
                        act_f = fima_pkg::ACT_SET_HI;
                        va_f  = cmd_reg.key - 1'b1;
                    end
                    else if (room)
                    begin
                        act_f = fima_pkg::ACT_SPLIT;
                        va_f  = cmd_reg.key - 1'b1;
                        vb_f  = cmd_reg.key + 1'b1;
                    end
                    else
                    begin
                        st_f = fima_pkg::ST_FULL;
                    end
                end
            end
            fima_pkg::OP_FREE:
            begin
                va_f = cmd_reg.key;
                if (!pa_s)
                begin
                    st_f = fima_pkg::ST_DONE;
                    if (pb_s && fc_s)
                    begin
                        act_f = fima_pkg::ACT_JOIN;
                    end
                    else if (fc_s)
                    begin
                        act_f = fima_pkg::ACT_SET_LO;
                    end
                    else if (pb_s)
                    begin
                        act_f = fima_pkg::ACT_PREV_HI;
                    end
                    else if (room)
                    begin
                        act_f = fima_pkg::ACT_INSERT;
                    end
                    else
                    begin
                        st_f = fima_pkg::ST_FULL;
                    end
                end
            end
            fima_pkg::OP_RUN:
            begin
                if (any_hit && cmd_reg.len != '0)
                begin
                    st_f = fima_pkg::ST_DONE;
                    if (fa_s)
                    begin
                        found_f = lo_sel;
                        if (fb_s)
                        begin
                            act_f = fima_pkg::ACT_DROP;
                        end
                        else
                        begin
                            act_f = fima_pkg::ACT_SET_LO;
                            va_f  = lo_sel + cmd_reg.len;
                        end
                    end
                    else if (fb_s)
                    begin
                        act_f = fima_pkg::ACT_SET_HI;
                        va_f  = cmd_reg.key - 1'b1;
                    end
                    else if (room)
                    begin
                        act_f = fima_pkg::ACT_SPLIT;
                        va_f  = cmd_reg.key - 1'b1;
                        vb_f  = cmd_reg.key + cmd_reg.len;
                    end
                    else
                    begin
                        st_f = fima_pkg::ST_FULL;
                    end
                end
            end
            default:
            begin
                st_f = fima_pkg::ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            sel_reg     <= '0;
            ge_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    state_reg <= S_FIND;
                end
                S_FIND:
                begin
                    state_reg   <= S_APPLY;
                    sel_reg     <= sel_x;
                    ge_reg      <= ge_x;
                end
                S_APPLY:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            cmd_reg.op  <= operation;
            cmd_reg.key <= key;
            cmd_reg.len <= run_length;
        end
        if (state_reg == S_FIND)
        begin
            ctl_reg.apply <= 1'b1;
            ctl_reg.act   <= act_f;
            ctl_reg.va    <= va_f;
            ctl_reg.vb    <= vb_f;
            status_reg    <= st_f;
            found_reg     <= found_f;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign status    = status_reg;
    assign found_key = found_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= fima_pkg::ST_FULL))
        else $error("undefined status code");

    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_v >> 1) & ~valid_v) == '0)
        else $error("valid intervals not packed at the low end");

    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(sel_reg))
        else $error("more than one selected cell");

endmodule

// ----- hw/rtl/fima_cell.sv -----
module fima_cell
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head,
    input  logic            eval,
    input  fima_pkg::cmd_t  cmd,
    input  fima_pkg::ctl_t  ctl,
    input  fima_pkg::pos_t  pos,
    input  fima_pkg::entry_t left,
    input  fima_pkg::entry_t right,
    output fima_pkg::entry_t ent,
    output fima_pkg::flags_t flags
);

    fima_pkg::entry_t entry_reg;
    fima_pkg::entry_t entry_next;
    fima_pkg::flags_t flags_reg;
    fima_pkg::flags_t flags_next;
    logic [fima_pkg::KEY_W-1:0] base;
    logic [fima_pkg::KEY_W-1:0] span;
    logic [fima_pkg::KEY_W-1:0] nm1;

    assign base = (entry_reg.lo >= cmd.key) ? entry_reg.lo : cmd.key;
    assign span = entry_reg.hi - base;
    assign nm1  = cmd.len - 1'b1;

    always_comb
    begin
        flags_next = '0;
        case (cmd.op)
            fima_pkg::OP_CLAIM:
            begin
                flags_next.hit = entry_reg.valid && entry_reg.lo <= cmd.key
                                 && cmd.key <= entry_reg.hi;
                flags_next.fa  = entry_reg.lo == cmd.key;
                flags_next.fb  = entry_reg.hi == cmd.key;
            end
            fima_pkg::OP_FREE:
            begin
                flags_next.hit = !entry_reg.valid || entry_reg.lo > cmd.key;
                flags_next.fa  = entry_reg.hi >= cmd.key;
                flags_next.fb  = ({1'b0, entry_reg.hi} + 1'b1) == {1'b0, cmd.key};
                flags_next.fc  = entry_reg.valid
                                 && {1'b0, entry_reg.lo} == ({1'b0, cmd.key} + 1'b1);
            end
            fima_pkg::OP_RUN:
            begin
                flags_next.hit = entry_reg.valid && entry_reg.hi >= cmd.key
                                 && span >= nm1;
                flags_next.fa  = entry_reg.lo >= cmd.key;
                flags_next.fb  = span == nm1;
            end
            default:
            begin
                flags_next = '0;
            end
        endcase
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.act)
            fima_pkg::ACT_DROP:
            begin
                if (pos.ge)
                begin
                    entry_next = right;
                end
            end
            fima_pkg::ACT_SET_LO:
            begin
                if (pos.sel)
                begin
                    entry_next.lo = ctl.va;
                end
            end
            fima_pkg::ACT_SET_HI:
            begin
                if (pos.sel)
                begin
                    entry_next.hi = ctl.va;
                end
            end
            fima_pkg::ACT_SPLIT:
            begin
                if (pos.sel)
                begin
                    entry_next.hi = ctl.va;
                end
                else if (pos.sel_prev)
                begin
                    entry_next    = left;
                    entry_next.lo = ctl.vb;
                end
                else if (pos.above)
                begin
                    entry_next = left;
                end
            end
            fima_pkg::ACT_JOIN:
            begin
                if (pos.sel_next)
                begin
                    entry_next.hi = right.hi;
                end
                else if (pos.ge)
                begin
                    entry_next = right;
                end
            end
            fima_pkg::ACT_INSERT:
            begin
                if (pos.sel)
                begin
                    entry_next.valid = 1'b1;
                    entry_next.lo    = ctl.va;
                    entry_next.hi    = ctl.va;
                end
                else if (pos.above)
                begin
                    entry_next = left;
                end
            end
            fima_pkg::ACT_PREV_HI:
            begin
                if (pos.sel_next)
                begin
                    entry_next.hi = ctl.va;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= head;
            entry_reg.lo    <= '0;
            entry_reg.hi    <= {fima_pkg::KEY_W{head}};
        end
        else if (ctl.apply)
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            flags_reg <= flags_next;
        end
    end

    assign ent   = entry_reg;
    assign flags = flags_reg;

endmodule

// ----- sim/fima_checker.sv -----
`timescale 1ns / 1ps
module fima_checker
    import fima_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic [1:0]       operation,
    input  logic [KEY_W-1:0] key,
    input  logic [KEY_W-1:0] run_length,
    input  logic             done,
    input  logic [1:0]       status,
    input  logic [KEY_W-1:0] found_key,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [1:0]       st;
        logic [KEY_W-1:0] fk;
    } outcome_t;

    logic [KEY_W-1:0] iv_lo [N_CELLS];
    logic [KEY_W-1:0] iv_hi [N_CELLS];
    int               iv_n;
    outcome_t         outcome_q[$];

    function automatic void drop_at(int p);
        for (int j = p; j + 1 < iv_n; j++)
        begin
            iv_lo[j] = iv_lo[j+1];
            iv_hi[j] = iv_hi[j+1];
        end
        iv_n--;
    endfunction

    function automatic void open_at(int p);
        for (int j = iv_n; j > p; j--)
        begin
            iv_lo[j] = iv_lo[j-1];
            iv_hi[j] = iv_hi[j-1];
        end
        iv_n++;
    endfunction

    function automatic logic [1:0] claim_one(logic [KEY_W-1:0] k);
        int i;
        for (i = 0; i < iv_n; i++)
            if (iv_lo[i] <= k && k <= iv_hi[i]) break;
        if (i >= iv_n) return ST_MISS;
        if (iv_lo[i] == k && iv_hi[i] == k) drop_at(i);
        else if (iv_lo[i] == k) iv_lo[i] = k + 1;
        else if (iv_hi[i] == k) iv_hi[i] = k - 1;
        else
        begin
            if (iv_n >= N_CELLS) return ST_FULL;
            open_at(i);
            iv_hi[i] = k - 1;
            iv_lo[i+1] = k + 1;
        end
        return ST_DONE;
    endfunction

    function automatic logic [1:0] free_one(logic [KEY_W-1:0] k);
        int i;
        bit jp, jn;
        for (i = 0; i < iv_n; i++)
            if (iv_lo[i] > k) break;
        if (i > 0 && iv_hi[i-1] >= k) return ST_MISS;
        jp = (i > 0) && ({1'b0, iv_hi[i-1]} + 1 == {1'b0, k});
        jn = (i < iv_n) && ({1'b0, iv_lo[i]} == {1'b0, k} + 1);
        if (jp && jn)
        begin
            iv_hi[i-1] = iv_hi[i];
            drop_at(i);
        end
        else if (jn) iv_lo[i] = k;
        else if (jp) iv_hi[i-1] = k;
        else
        begin
            if (iv_n >= N_CELLS) return ST_FULL;
            open_at(i);
            iv_lo[i] = k;
            iv_hi[i] = k;
        end
        return ST_DONE;
    endfunction

    function automatic logic [1:0] claim_span(logic [KEY_W-1:0] m, logic [KEY_W-1:0] n,
                                              output logic [KEY_W-1:0] first);
        logic [KEY_W-1:0] s, e, nm1;
        first = m;
        if (n == 0) return ST_MISS;
        nm1 = n - 1;
        for (int i = 0; i < iv_n; i++)
        begin
            s = iv_lo[i];
            e = iv_hi[i];
            if (e < m || (e - s) < nm1) continue;
            if (s >= m)
            begin
                first = s;
                if (e - s == nm1) drop_at(i);
                else iv_lo[i] = s + n;
                return ST_DONE;
            end
            if (e - m >= nm1)
            begin
                if (e - m == nm1) iv_hi[i] = m - 1;
                else
                begin
                    if (iv_n >= N_CELLS) return ST_FULL;
                    open_at(i);
                    iv_hi[i] = m - 1;
                    iv_lo[i+1] = m + n;
                    iv_hi[i+1] = e;
                end
                return ST_DONE;
            end
        end
        return ST_MISS;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o, x;
        if (!rst_n)
        begin
            iv_n = 1;
            iv_lo[0] = '0;
            iv_hi[0] = '1;
            outcome_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    x = outcome_q.pop_front();
                    if (status !== x.st)
                    begin
                        $error("status: expected %0d, actual %0d", x.st, status);
                        fail_count++;
                    end
                    if (found_key !== x.fk)
                    begin
                        $error("found_key: expected %h, actual %h", x.fk, found_key);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                o.fk = key;
                case (operation)
                    OP_CLAIM: o.st = claim_one(key);
                    OP_FREE:  o.st = free_one(key);
                    OP_RUN:
                    begin
                        o.st = claim_span(key, run_length, o.fk);
                        if (o.st != ST_DONE) o.fk = key;
                    end
                    default:  o.st = ST_MISS;
                endcase
                outcome_q.push_back(o);
            end
            pending = outcome_q.size();
        end
    end

endmodule

// ----- sim/tb_free_interval_map_allocator_unit.sv -----
`timescale 1ns / 1ps
module tb_free_interval_map_allocator_unit;
    import fima_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       operation;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] run_length;
    logic             done;
    logic [1:0]       status;
    logic [KEY_W-1:0] found_key;
    int               fail_count;
    int               pending;
    int               n_sent;

    free_interval_map_allocator_unit u_top (.*);

    fima_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send(logic [1:0] op, logic [KEY_W-1:0] k, logic [KEY_W-1:0] n);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        repeat (gap) @(negedge clk);
        start = 1'b1;
        operation = op;
        key = k;
        run_length = n;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start = 1'b0;
        n_sent++;
    endtask

    function automatic logic [KEY_W-1:0] near_key(int sel);
        case (sel)
            0: return $urandom_range(0, 300);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 300);
            2: return 32'h8000_0000 + $urandom_range(0, 300) - 150;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [KEY_W-1:0] k;
        int r;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_CLAIM;
        key = '0;
        run_length = '0;
        n_sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send(OP_CLAIM, 32'd0, 32'd0);
        send(OP_CLAIM, 32'd0, 32'd0);
        send(OP_FREE, 32'd5, 32'd0);
        send(OP_CLAIM, 32'hFFFF_FFFF, 32'd0);
        send(OP_CLAIM, 32'd100, 32'd0);
        send(OP_FREE, 32'd100, 32'd0);
        send(OP_FREE, 32'hFFFF_FFFF, 32'd0);
        send(OP_FREE, 32'd0, 32'd0);
        send(OP_RUN, 32'd10, 32'd0);
        send(OP_RUN, 32'd0, 32'd16);
        send(OP_RUN, 32'd1000, 32'd4);
        send(OP_RUN, 32'd1004, 32'd2);
        send(OP_RUN, 32'd0, 32'hFFFF_FFFF);
        send(OP_RUN, 32'hFFFF_FFF0, 32'd16);
        send(OP_RUN, 32'hFFFF_FFF0, 32'd1);
        send(OP_UNDEF, 32'd7, 32'd7);
        send(OP_FREE, 32'hFFFF_FFF5, 32'd0);
        send(OP_FREE, 32'd1001, 32'd0);
        send(OP_FREE, 32'd1000, 32'd0);
        for (int i = 0; i < 70; i++)
            send(OP_CLAIM, 32'd2000 + 2 * i, 32'd0);
        send(OP_FREE, 32'd2001, 32'd0);
        send(OP_FREE, 32'd2300, 32'd0);
        send(OP_RUN, 32'd5001, 32'd3);

        wait (pending == 0);
        repeat (8) @(negedge clk);

        while (n_sent < 1800)
        begin
            r = $urandom_range(0, 19);
            k = near_key($urandom_range(0, 4));
            if (r < 8) send(OP_CLAIM, k, $urandom());
            else if (r < 15) send(OP_FREE, k, $urandom());
            else if (r < 18)
                send(OP_RUN, k, $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom());
            else send(OP_UNDEF, k, $urandom());
        end

        wait (pending == 0);
        repeat (10) @(negedge clk);
        $display("Sent %0d commands: single claims and frees, run claims, full-table cases.",
                 n_sent);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
